// ===== hw/rtl/mp3hd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3hd_pkg
// Shared types, field codes and decode tables for the Layer III header decoder.
// ----------------------------------------------------------------------------
package mp3hd_pkg;

  // Field widths of one result.
  localparam int unsigned HDR_W    = 32;
  localparam int unsigned VER_W    = 2;
  localparam int unsigned KBPS_W   = 9;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned SPF_W    = 11;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned MULT_W   = 9;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned OUT_W    = 56;

  // Division by 49 as a multiplication by a rounded-up reciprocal.
  // Exact for every numerator below 2**16.
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_49 = 17'd85599;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  // Header field codes.
  localparam logic [1:0] VER_MPEG1    = 2'd3;
  localparam logic [1:0] VER_MPEG2    = 2'd2;
  localparam logic [1:0] VER_MPEG25   = 2'd0;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] LAYER_III    = 2'd1;
  localparam logic [3:0] BRI_FREE     = 4'd0;
  localparam logic [3:0] BRI_BAD      = 4'd15;
  localparam logic [1:0] SRI_44100    = 2'd0;
  localparam logic [1:0] SRI_48000    = 2'd1;
  localparam logic [1:0] SRI_32000    = 2'd2;
  localparam logic [1:0] SRI_RESERVED = 2'd3;
  localparam logic [1:0] MODE_MONO    = 2'd3;

  localparam logic [SPF_W-1:0]  SPF_MPEG1  = 11'd1152;
  localparam logic [SPF_W-1:0]  SPF_OTHER  = 11'd576;
  localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_MULTI = 2'd2;

  // Divisor that finishes the frame length computation.
  typedef enum logic [1:0] {
    DIV_1,
    DIV_2,
    DIV_49
  } div_sel_e;

  // Decoded header fields that travel down the pipeline.
  typedef struct packed {
    logic                 valid_res;
    logic [VER_W-1:0]     version_code;
    logic [KBPS_W-1:0]    bitrate_kbps;
    logic [RATE_W-1:0]    sample_rate_hz;
    logic [SPF_W-1:0]     samples_per_frame;
    logic                 padding;
    logic [CHAN_W-1:0]    channel_count;
    logic                 crc_present;
    logic [MULT_W-1:0]    len_mult;
    div_sel_e             div_sel;
  } hdr_info_t;

  // MPEG-1 Layer III bitrate table, indexed by the bitrate index.
  function automatic logic [KBPS_W-1:0] kbps_mpeg1(input logic [3:0] bri);
    logic [KBPS_W-1:0] kbps;
    case (bri)
      4'd1:    kbps = 9'd32;
      4'd2:    kbps = 9'd40;
      4'd3:    kbps = 9'd48;
      4'd4:    kbps = 9'd56;
      4'd5:    kbps = 9'd64;
      4'd6:    kbps = 9'd80;
      4'd7:    kbps = 9'd96;
      4'd8:    kbps = 9'd112;
      4'd9:    kbps = 9'd128;
      4'd10:   kbps = 9'd160;
      4'd11:   kbps = 9'd192;
      4'd12:   kbps = 9'd224;
      4'd13:   kbps = 9'd256;
      4'd14:   kbps = 9'd320;
      default: kbps = '0;
    endcase
    return kbps;
  endfunction

  // MPEG-2 and MPEG-2.5 Layer III bitrate table.
  function automatic logic [KBPS_W-1:0] kbps_mpeg2(input logic [3:0] bri);
    logic [KBPS_W-1:0] kbps;
    case (bri)
      4'd1:    kbps = 9'd8;
      4'd2:    kbps = 9'd16;
      4'd3:    kbps = 9'd24;
      4'd4:    kbps = 9'd32;
      4'd5:    kbps = 9'd40;
      4'd6:    kbps = 9'd48;
      4'd7:    kbps = 9'd56;
      4'd8:    kbps = 9'd64;
      4'd9:    kbps = 9'd80;
      4'd10:   kbps = 9'd96;
      4'd11:   kbps = 9'd112;
      4'd12:   kbps = 9'd128;
      4'd13:   kbps = 9'd144;
      4'd14:   kbps = 9'd160;
      default: kbps = '0;
    endcase
    return kbps;
  endfunction

  // MPEG-1 base sampling rate.
  function automatic logic [RATE_W-1:0] base_rate(input logic [1:0] sri);
    logic [RATE_W-1:0] rate;
    case (sri)
      SRI_44100: rate = 16'd44100;
      SRI_48000: rate = 16'd48000;
      SRI_32000: rate = 16'd32000;
      default:   rate = '0;
    endcase
    return rate;
  endfunction

endpackage

// ===== hw/rtl/mp3hd_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3hd_parse
// First stage: checks a candidate header word and decodes its table fields.
// ----------------------------------------------------------------------------
module mp3hd_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [mp3hd_pkg::HDR_W-1:0]    hdr_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output mp3hd_pkg::hdr_info_t           info_o
);

  logic                  valid_q;
  mp3hd_pkg::hdr_info_t  info_d, info_q;

  logic       sync_ok;
  logic       hdr_ok;
  logic [1:0] ver;
  logic [1:0] lay;
  logic [3:0] bri;
  logic [1:0] sri;
  logic       is_mpeg1;
  logic       is_mpeg25;

  // Field extraction and validity check.
  assign sync_ok   = &hdr_i[31:21];
  assign ver       = hdr_i[20:19];
  assign lay       = hdr_i[18:17];
  assign bri       = hdr_i[15:12];
  assign sri       = hdr_i[11:10];
  assign is_mpeg1  = (ver == mp3hd_pkg::VER_MPEG1);
  assign is_mpeg25 = (ver == mp3hd_pkg::VER_MPEG25);
  assign hdr_ok    = sync_ok && (ver != mp3hd_pkg::VER_RESERVED) &&
                     (lay == mp3hd_pkg::LAYER_III) &&
                     (bri != mp3hd_pkg::BRI_FREE) && (bri != mp3hd_pkg::BRI_BAD) &&
                     (sri != mp3hd_pkg::SRI_RESERVED);

  // Table decode. The frame length is floor(K * kbps / base) with K = 144000,
  // or 288000 for MPEG-2.5, which reduces to a small multiplier per base rate.
  always_comb begin
    info_d = '0;
    if (hdr_ok) begin
      info_d.valid_res    = 1'b1;
      info_d.version_code = ver;
      info_d.bitrate_kbps = is_mpeg1 ? mp3hd_pkg::kbps_mpeg1(bri)
                                     : mp3hd_pkg::kbps_mpeg2(bri);
      case (ver)
        mp3hd_pkg::VER_MPEG1:  info_d.sample_rate_hz = mp3hd_pkg::base_rate(sri);
        mp3hd_pkg::VER_MPEG2:  info_d.sample_rate_hz = mp3hd_pkg::base_rate(sri) >> 1;
        mp3hd_pkg::VER_MPEG25: info_d.sample_rate_hz = mp3hd_pkg::base_rate(sri) >> 2;
        default:               info_d.sample_rate_hz = '0;
      endcase
      info_d.samples_per_frame = is_mpeg1 ? mp3hd_pkg::SPF_MPEG1 : mp3hd_pkg::SPF_OTHER;
      info_d.padding           = hdr_i[9];
      info_d.channel_count     = (hdr_i[7:6] == mp3hd_pkg::MODE_MONO) ?
                                 mp3hd_pkg::CHAN_MONO : mp3hd_pkg::CHAN_MULTI;
      info_d.crc_present       = ~hdr_i[16];
      case (sri)
        mp3hd_pkg::SRI_44100: begin
          info_d.len_mult = is_mpeg25 ? 9'd320 : 9'd160;
          info_d.div_sel  = mp3hd_pkg::DIV_49;
        end
        mp3hd_pkg::SRI_48000: begin
          info_d.len_mult = is_mpeg25 ? 9'd6 : 9'd3;
          info_d.div_sel  = mp3hd_pkg::DIV_1;
        end
        default: begin
          info_d.len_mult = is_mpeg25 ? 9'd18 : 9'd9;
          info_d.div_sel  = mp3hd_pkg::DIV_2;
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign info_o  = info_q;

endmodule

// ===== hw/rtl/mp3hd_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3hd_mult
// Second and third stages: frame length numerator and reciprocal product.
// ----------------------------------------------------------------------------
module mp3hd_mult (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  mp3hd_pkg::hdr_info_t              info_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output mp3hd_pkg::hdr_info_t              info_o,
  output logic [mp3hd_pkg::NUM_W-1:0]       num_o,
  output logic [mp3hd_pkg::PROD_W-1:0]      prod_o
);

  logic                               num_valid_q;
  logic                               num_ready;
  mp3hd_pkg::hdr_info_t               num_info_q;
  logic [mp3hd_pkg::NUM_W-1:0]        num_d, num_q;

  logic                               prod_valid_q;
  mp3hd_pkg::hdr_info_t               prod_info_q;
  logic [mp3hd_pkg::NUM_W-1:0]        prod_num_q;
  logic [mp3hd_pkg::PROD_W-1:0]       prod_d, prod_q;

  // Numerator: bitrate times the per-rate multiplier, at most 51200.
  assign num_d = mp3hd_pkg::NUM_W'(info_i.bitrate_kbps) *
                 mp3hd_pkg::NUM_W'(info_i.len_mult);

  assign ready_o   = !num_valid_q || num_ready;
  assign num_ready = !prod_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_valid_q <= 1'b0;
    end else if (ready_o) begin
      num_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      num_info_q <= info_i;
      num_q      <= num_d;
    end
  end

  // Reciprocal product for the division by 49.
  assign prod_d = mp3hd_pkg::PROD_W'(num_q) * mp3hd_pkg::PROD_W'(mp3hd_pkg::RECIP_49);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (num_ready) begin
      prod_valid_q <= num_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_ready && num_valid_q) begin
      prod_info_q <= num_info_q;
      prod_num_q  <= num_q;
      prod_q      <= prod_d;
    end
  end

  assign valid_o = prod_valid_q;
  assign info_o  = prod_info_q;
  assign num_o   = prod_num_q;
  assign prod_o  = prod_q;

endmodule

// ===== hw/rtl/mp3_layer3_header_decode_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_layer3_header_decode_core
// Layer III frame header decoder: validity, version, bitrate, sample rate,
// samples per frame, frame length, channel count and CRC flag.
// ----------------------------------------------------------------------------
// Throughput: one header word per cycle while the output is not stalled;
// four pipeline registers (parse, numerator, product, output), the third
// holding the 16 x 17 reciprocal product that replaces the division by 49.
// Each stage takes a new request when it is empty or its successor moves.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module mp3_layer3_header_decode_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] header_word
  input  logic [mp3hd_pkg::HDR_W-1:0]      s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] valid_res, [2:1] version_code, [11:3] bitrate_kbps,
  // [27:12] sample_rate_hz, [38:28] samples_per_frame, [49:39] frame_length,
  // [51:50] channel_count, [52] crc_present, [55:53] zero
  output logic [mp3hd_pkg::OUT_W-1:0]      m_axis_tdata_o
);

  logic                            parse_valid;
  logic                            parse_ready;
  mp3hd_pkg::hdr_info_t            parse_info;

  logic                            mult_valid;
  logic                            mult_ready;
  mp3hd_pkg::hdr_info_t            mult_info;
  logic [mp3hd_pkg::NUM_W-1:0]     mult_num;
  logic [mp3hd_pkg::PROD_W-1:0]    mult_prod;

  logic                            out_valid_q;
  logic [mp3hd_pkg::LEN_W-1:0]     quot;
  logic [mp3hd_pkg::OUT_W-1:0]     out_data_d, out_data_q;

  mp3hd_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .hdr_i   (s_axis_tdata_i),
    .valid_o (parse_valid),
    .ready_i (parse_ready),
    .info_o  (parse_info)
  );

  mp3hd_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (parse_valid),
    .ready_o (parse_ready),
    .info_i  (parse_info),
    .valid_o (mult_valid),
    .ready_i (mult_ready),
    .info_o  (mult_info),
    .num_o   (mult_num),
    .prod_o  (mult_prod)
  );

  // Quotient select by divisor; invalid headers carry a zero numerator.
  always_comb begin
    case (mult_info.div_sel)
      mp3hd_pkg::DIV_1:  quot = mult_num[mp3hd_pkg::LEN_W-1:0];
      mp3hd_pkg::DIV_2:  quot = mult_num[mp3hd_pkg::LEN_W:1];
      mp3hd_pkg::DIV_49: quot = mult_prod[mp3hd_pkg::RECIP_SHIFT +: mp3hd_pkg::LEN_W];
      default:           quot = '0;
    endcase
  end

  // Output packing with the padding byte added.
  assign out_data_d = {3'b000,
                       mult_info.crc_present,
                       mult_info.channel_count,
                       quot + mp3hd_pkg::LEN_W'(mult_info.padding),
                       mult_info.samples_per_frame,
                       mult_info.sample_rate_hz,
                       mult_info.bitrate_kbps,
                       mult_info.version_code,
                       mult_info.valid_res};

  assign mult_ready = !out_valid_q || m_axis_tready_i;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mult_ready) begin
      out_valid_q <= mult_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mult_ready && mult_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== tb/mp3_hdr_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_hdr_check
// Watches both stream channels of the Layer III header decoder. For every
// accepted request it decodes the header word itself and queues the decoded
// fields. Every accepted result is then compared field by field with the
// oldest queued entry. It reports the mismatch count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module mp3_hdr_check
  import mp3hd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [HDR_W-1:0]     s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OUT_W-1:0]     m_tdata_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          pending_o
);

  // Result word layout, highest field first.
  typedef struct packed {
    logic [OUT_W-54:0]   zero_fill;
    logic                crc_present;
    logic [CHAN_W-1:0]   channel_count;
    logic [LEN_W-1:0]    frame_length;
    logic [SPF_W-1:0]    samples_per_frame;
    logic [RATE_W-1:0]   sample_rate_hz;
    logic [KBPS_W-1:0]   bitrate_kbps;
    logic [VER_W-1:0]    version_code;
    logic                valid_res;
  } hdr_res_t;

  // Layer III bitrate tables in kbit/s, entry for index 1 in the lowest bits.
  localparam logic [14*9-1:0] KBPS_M1_TAB = {
    9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128, 9'd112,
    9'd96,  9'd80,  9'd64,  9'd56,  9'd48,  9'd40,  9'd32
  };
  localparam logic [14*9-1:0] KBPS_M2_TAB = {
    9'd160, 9'd144, 9'd128, 9'd112, 9'd96, 9'd80, 9'd64,
    9'd56,  9'd48,  9'd40,  9'd32,  9'd24, 9'd16, 9'd8
  };

  hdr_res_t    decoded_q[$];
  hdr_res_t    got;
  hdr_res_t    want;
  int unsigned bad;

  // Decodes one candidate header word; anything rejected gives all zeros.
  function automatic hdr_res_t decode_header(input logic [HDR_W-1:0] w);
    hdr_res_t    r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  sri;
    logic [3:0]  bri;
    logic        mpeg1;
    int unsigned hz;
    int unsigned kbps;
    int unsigned coef;
    int unsigned len;
    r   = '0;
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    sri = w[11:10];
    if (w[31:21] != 11'h7FF || ver == VER_RESERVED || lay != LAYER_III ||
        bri == BRI_FREE || bri == BRI_BAD || sri == SRI_RESERVED) begin
      return r;
    end
    case (sri)
      SRI_44100: hz = 44100;
      SRI_48000: hz = 48000;
      default:   hz = 32000;
    endcase
    if (ver == VER_MPEG2) begin
      hz = hz / 2;
    end else if (ver == VER_MPEG25) begin
      hz = hz / 4;
    end
    mpeg1 = (ver == VER_MPEG1);
    kbps  = mpeg1 ? KBPS_M1_TAB[(bri - 1) * 9 +: 9] : KBPS_M2_TAB[(bri - 1) * 9 +: 9];
    coef  = mpeg1 ? 144000 : 72000;
    len   = (coef * kbps) / hz + w[9];
    // A length outside the legal byte range also rejects the word.
    if (len < 24 || len > 65535) begin
      return r;
    end
    r.valid_res         = 1'b1;
    r.version_code      = ver;
    r.bitrate_kbps      = kbps[KBPS_W-1:0];
    r.sample_rate_hz    = hz[RATE_W-1:0];
    r.samples_per_frame = mpeg1 ? 11'd1152 : 11'd576;
    r.frame_length      = len[LEN_W-1:0];
    r.channel_count     = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    r.crc_present       = ~w[16];
    return r;
  endfunction

  // Compares one field and counts a mismatch.
  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      bad++;
    end
  endtask

  // Retire results first, then queue the decode of a newly accepted request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      pending_o      <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      bad = 0;
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (decoded_q.size() == 0) begin
          $error("result %h arrived with no request outstanding", m_tdata_i);
          bad++;
        end else begin
          want = decoded_q.pop_front();
          check_field("valid_res", want.valid_res, got.valid_res);
          check_field("version_code", want.version_code, got.version_code);
          check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
          check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
          check_field("samples_per_frame", want.samples_per_frame,
                      got.samples_per_frame);
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("channel_count", want.channel_count, got.channel_count);
          check_field("crc_present", want.crc_present, got.crc_present);
          check_field("zero_fill", want.zero_fill, got.zero_fill);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decoded_q.push_back(decode_header(s_tdata_i));
      end
      pending_o      <= decoded_q.size();
      mismatch_cnt_o <= mismatch_cnt_o + bad;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Layer III header decoder: a directed set of headers at the
// edges of every field, then mostly well-formed random headers mixed with
// noise and broken sync. Both channels stall in random bursts; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mp3hd_pkg::*;

  logic             clk     = 1'b0;
  logic             rst_n   = 1'b0;
  logic             s_valid = 1'b0;
  logic [HDR_W-1:0] s_data  = '0;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;
  int unsigned      mismatch_cnt;
  int unsigned      pending;
  bit               idle_en = 1'b1;
  int unsigned      stall_left = 0;

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  mp3_layer3_header_decode_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  mp3_hdr_check u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_tvalid_i     (s_valid),
    .s_tready_i     (s_ready),
    .s_tdata_i      (s_data),
    .m_tvalid_i     (m_valid),
    .m_tready_i     (m_ready),
    .m_tdata_i      (m_data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // Assembles a header word with the sync field set.
  function automatic logic [HDR_W-1:0] build_hdr(input logic [1:0] ver,
      input logic [1:0] lay, input logic prot, input logic [3:0] bri,
      input logic [1:0] sri, input logic pad, input logic [1:0] mode,
      input logic [6:0] misc);
    return {11'h7FF, ver, lay, prot, bri, sri, pad, misc[6], mode, misc[5:0]};
  endfunction

  // Mostly well-formed headers with random content, some noise, some broken sync.
  function automatic logic [HDR_W-1:0] rand_word();
    logic [HDR_W-1:0] w;
    logic [1:0]       ver;
    logic [1:0]       lay;
    logic [1:0]       sri;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return $urandom;
    end
    case ($urandom_range(0, 9))
      0:       ver = VER_RESERVED;
      1, 2, 3: ver = VER_MPEG2;
      4, 5:    ver = VER_MPEG25;
      default: ver = VER_MPEG1;
    endcase
    sri = ($urandom_range(0, 9) == 0) ? SRI_RESERVED : 2'($urandom_range(0, 2));
    lay = ($urandom_range(0, 9) == 0) ? 2'($urandom) : LAYER_III;
    w = build_hdr(ver, lay, 1'($urandom), 4'($urandom), sri, 1'($urandom),
                  2'($urandom), 7'($urandom));
    if (pick < 22) begin
      w[$urandom_range(21, 31)] = 1'b0;
    end
    return w;
  endfunction

  // Offers one request, with an occasional gap ahead of it, and waits for it.
  task automatic send_word(input logic [HDR_W-1:0] w);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= w;
    do @(posedge clk); while (!s_ready);
  endtask

  // Receiver stalls in random bursts while idling is enabled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Main sequence.
  initial begin
    int unsigned n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // Directed headers: rejects first, then the extremes of each valid field.
    send_word('0);
    send_word('1);
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRI_44100, 1'b0,
                        2'd0, 7'd0) & ~32'h0020_0000);
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRI_44100, 1'b0,
                        2'd0, 7'd0) & ~32'h8000_0000);
    send_word(build_hdr(VER_RESERVED, LAYER_III, 1'b1, 4'd9, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, 2'd0, 1'b1, 4'd9, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, 2'd2, 1'b1, 4'd9, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG2, 2'd3, 1'b1, 4'd9, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b1, BRI_FREE, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG2, LAYER_III, 1'b1, BRI_BAD, SRI_48000, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG25, LAYER_III, 1'b1, 4'd5, SRI_RESERVED, 1'b0, 2'd0, 7'd0));
    // Longest frame: MPEG-1, 320 kbit/s, 32 kHz, padded.
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b0, 4'd14, SRI_32000, 1'b1,
                        2'd1, 7'h7F));
    // Shortest frame: MPEG-2, 8 kbit/s, 24 kHz, no padding.
    send_word(build_hdr(VER_MPEG2, LAYER_III, 1'b1, 4'd1, SRI_48000, 1'b0,
                        MODE_MONO, 7'd0));
    send_word(build_hdr(VER_MPEG25, LAYER_III, 1'b0, 4'd1, SRI_32000, 1'b1, 2'd2, 7'h2A));
    send_word(build_hdr(VER_MPEG25, LAYER_III, 1'b1, 4'd14, SRI_44100, 1'b0,
                        MODE_MONO, 7'h55));
    send_word(build_hdr(VER_MPEG2, LAYER_III, 1'b0, 4'd14, SRI_44100, 1'b1, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRI_44100, 1'b0, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRI_44100, 1'b1, 2'd0, 7'd0));
    send_word(build_hdr(VER_MPEG1, LAYER_III, 1'b0, 4'd1, SRI_48000, 1'b0,
                        MODE_MONO, 7'h7F));
    send_word(build_hdr(VER_MPEG2, LAYER_III, 1'b0, 4'd7, SRI_32000, 1'b1, 2'd1, 7'h11));

    // Hold off until the pipeline has drained completely. The checker's count
    // includes the last request only from the next edge on.
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random headers; the last stretch runs with no idling on either side.
    for (n = 0; n < 480; n++) begin
      if (n >= 380) begin
        idle_en = 1'b0;
      end else if (n % 50 == 0) begin
        idle_en = ($urandom_range(0, 3) != 0);
      end
      send_word(rand_word());
    end
    s_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
